FILE: rtl/scc_strong_augment_count_defines.svh
// Assertion macros shared by the block's RTL.
`ifndef SCC_STRONG_AUGMENT_COUNT_DEFINES_SVH
`define SCC_STRONG_AUGMENT_COUNT_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define SCC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A consequence that must follow from an antecedent in the same cycle.
`define SCC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/scc_pkg.sv
package scc_pkg;

  // Sequencer states of the component search.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_CNT_RD,
    ST_CNT_CHK,
    ST_CNT_WR,
    ST_PFX_RD,
    ST_PFX_WR,
    ST_SCT_RD,
    ST_SCT_CHK,
    ST_SCT_WR,
    ST_OUT_A,
    ST_OUT_B,
    ST_OUT_C,
    ST_VISIT,
    ST_ADJ,
    ST_TGT,
    ST_UCHK,
    ST_POP,
    ST_VCLR,
    ST_MRK_RD,
    ST_MRK_A,
    ST_MRK_B,
    ST_MRK_C,
    ST_TAL_RD,
    ST_TAL_ACC,
    ST_DONE
  } scc_state_e;

endpackage

FILE: rtl/scc_strong_augment_count.sv
// Strong-connectivity augmentation counter.
// Input stream: one request per cycle while the block is idle; each carries a directed edge,
// tdata = {dst_node, src_node}, tuser = edge_valid (0 marks an empty item), tlast = last item
// of the graph. Edges are stored at one per cycle while idle. Edges with a node at or above
// node_count, or arriving once MAX_EDGES are stored, are dropped and flagged.
// On the last request the block stops accepting and runs the component search held in
// single-port-read memories: table build, forward walk, reverse walk, edge marking and a
// tally, driven by a read-modify-write sequencer.
// The result (extra_edges, component_count in tdata, edge_dropped in tuser) then waits in
// the output register; an earlier result still held there keeps the block in its final state
// until the receiver takes it, after which input requests are accepted again.
// cfg_we_i writes node_count (reset value 1); the user must write it only while the block is
// idle, which the block itself does not enforce. Reset empties the edge store and clears the
// output; memory contents are not cleared, each run clears and rebuilds the tables it reads.
`include "scc_strong_augment_count_defines.svh"

module scc_strong_augment_count #(
  parameter int MAX_NODES = 256,
  parameter int MAX_EDGES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // src_node [7:0], dst_node [15:8]
  input  logic        s_axis_tuser,   // edge_valid
  input  logic        s_axis_tlast,   // last_edge
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // extra_edges [8:0], component_count [17:9], zeros
  output logic        m_axis_tuser    // edge_dropped
);

  import scc_pkg::*;

  localparam int NW   = $clog2(MAX_NODES);
  localparam int NCW  = $clog2(MAX_NODES + 1);
  localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW  = $clog2(MAX_EDGES + 1);
  localparam int CMPW = (NCW > 9) ? NCW : 9;
  localparam int AJW  = 2 * ECW;

  scc_state_e state_q, state_d;
  logic [CMPW-1:0] idx_q, idx_d;
  logic [ECW-1:0]  eidx_q, eidx_d, total_q, total_d;
  logic [ECW-1:0]  sumf_q, sumf_d, sumr_q, sumr_d;
  logic            drop_q, drop_d, pass2_q, pass2_d;
  logic [NW-1:0]   a_q, a_d, b_q, b_d, cand_q, cand_d, top_q, top_d;
  logic [NW-1:0]   u_q, u_d, ca_q, ca_d;
  logic [NCW-1:0]  depth_q, depth_d, ftot_q, ftot_d, ccnt_q, ccnt_d;
  logic [NCW-1:0]  nsrc_q, nsrc_d, nsnk_q, nsnk_d;
  logic [8:0]      node_count_q;
  logic            m_valid_q, m_valid_d, m_user_q, m_user_d;
  logic [23:0]     m_data_q, m_data_d;

  // Memory ports.
  logic            e_we, e_re;
  logic [EAW-1:0]  e_wa, e_ra;
  logic [15:0]     e_wd, e_rd;
  logic            fadj_we, fadj_re, radj_we, radj_re;
  logic [NW-1:0]   fadj_wa, fadj_ra, radj_wa, radj_ra;
  logic [AJW-1:0]  fadj_wd, fadj_rd, radj_wd, radj_rd;
  logic            ftgt_we, ftgt_re, rtgt_we, rtgt_re;
  logic [EAW-1:0]  ftgt_wa, ftgt_ra, rtgt_wa, rtgt_ra;
  logic [NW-1:0]   ftgt_wd, ftgt_rd, rtgt_wd, rtgt_rd;
  logic            vis_we, vis_re, vis_wd, vis_rd;
  logic [NW-1:0]   vis_wa, vis_ra;
  logic            ford_we, ford_re, comp_we, comp_re, stk_we, stk_re;
  logic [NW-1:0]   ford_wa, ford_ra, ford_wd, ford_rd;
  logic [NW-1:0]   comp_wa, comp_ra, comp_wd, comp_rd;
  logic [NW-1:0]   stk_wa, stk_ra, stk_wd, stk_rd;
  logic            hout_we, hout_re, hout_wd, hout_rd;
  logic            hin_we, hin_re, hin_wd, hin_rd;
  logic [NW-1:0]   hout_wa, hout_ra, hin_wa, hin_ra;

  logic [CMPW-1:0] n_use, n_last;
  logic            s_in_range, e_in_range, advance;
  logic [AJW-1:0]  adj_rd;
  logic [ECW-1:0]  adj_cur, adj_end, cf, cr, sf, sr;
  logic [NW-1:0]   tgt_rd;
  logic [NCW-1:0]  max_ss;

  // Nodes in use: zero counts as one, large values saturate.
  always_comb begin
    n_use = CMPW'(node_count_q);
    if (node_count_q == 9'd0) begin
      n_use = CMPW'(1);
    end else if (CMPW'(node_count_q) > CMPW'(MAX_NODES)) begin
      n_use = CMPW'(MAX_NODES);
    end
  end
  assign n_last = n_use - CMPW'(1);

  assign s_in_range = (CMPW'(s_axis_tdata[7:0]) < n_use) && (CMPW'(s_axis_tdata[15:8]) < n_use);
  assign e_in_range = (CMPW'(e_rd[7:0]) < n_use) && (CMPW'(e_rd[15:8]) < n_use);

  // Adjacency entries hold the walk cursor over the end of the node's target list.
  assign adj_rd  = pass2_q ? radj_rd : fadj_rd;
  assign adj_cur = adj_rd[AJW-1:ECW];
  assign adj_end = adj_rd[ECW-1:0];
  assign tgt_rd  = pass2_q ? rtgt_rd : ftgt_rd;
  assign cf      = fadj_rd[AJW-1:ECW] - ECW'(1);
  assign cr      = radj_rd[AJW-1:ECW] - ECW'(1);
  assign sf      = sumf_q + fadj_rd[ECW-1:0];
  assign sr      = sumr_q + radj_rd[ECW-1:0];
  assign max_ss  = (nsrc_q > nsnk_q) ? nsrc_q : nsnk_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // Sequencer: next state, register updates and memory accesses.
  always_comb begin
    state_d = state_q;   idx_d = idx_q;     eidx_d = eidx_q;   total_d = total_q;
    sumf_d = sumf_q;     sumr_d = sumr_q;   drop_d = drop_q;   pass2_d = pass2_q;
    a_d = a_q;           b_d = b_q;         cand_d = cand_q;   top_d = top_q;
    u_d = u_q;           ca_d = ca_q;       depth_d = depth_q; ftot_d = ftot_q;
    ccnt_d = ccnt_q;     nsrc_d = nsrc_q;   nsnk_d = nsnk_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d = m_data_q; m_user_d = m_user_q;
    advance = 1'b0;

    e_we = 1'b0;    e_wa = total_q[EAW-1:0]; e_wd = s_axis_tdata;
    e_re = 1'b0;    e_ra = eidx_q[EAW-1:0];
    fadj_we = 1'b0; fadj_wa = a_q; fadj_wd = '0; fadj_re = 1'b0; fadj_ra = a_q;
    radj_we = 1'b0; radj_wa = b_q; radj_wd = '0; radj_re = 1'b0; radj_ra = b_q;
    ftgt_we = 1'b0; ftgt_wa = cf[EAW-1:0]; ftgt_wd = b_q;
    ftgt_re = 1'b0; ftgt_ra = adj_cur[EAW-1:0];
    rtgt_we = 1'b0; rtgt_wa = cr[EAW-1:0]; rtgt_wd = a_q;
    rtgt_re = 1'b0; rtgt_ra = adj_cur[EAW-1:0];
    vis_we = 1'b0;  vis_wa = idx_q[NW-1:0]; vis_wd = 1'b0; vis_re = 1'b0; vis_ra = cand_q;
    ford_we = 1'b0; ford_wa = ftot_q[NW-1:0]; ford_wd = top_q;
    ford_re = 1'b0; ford_ra = idx_q[NW-1:0];
    comp_we = 1'b0; comp_wa = cand_q; comp_wd = NW'(ccnt_q); comp_re = 1'b0; comp_ra = a_q;
    stk_we = 1'b0;  stk_wa = depth_q[NW-1:0]; stk_wd = u_q;
    stk_re = 1'b0;  stk_ra = NW'(depth_q - NCW'(2));
    hout_we = 1'b0; hout_wa = ca_q; hout_wd = 1'b1; hout_re = 1'b0; hout_ra = idx_q[NW-1:0];
    hin_we = 1'b0;  hin_wa = comp_rd; hin_wd = 1'b1; hin_re = 1'b0; hin_ra = idx_q[NW-1:0];

    case (state_q)
      // Store edges as they arrive.
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser) begin
            if (s_in_range && (total_q < ECW'(MAX_EDGES))) begin
              e_we    = 1'b1;
              total_d = total_q + ECW'(1);
            end else begin
              drop_d = 1'b1;
            end
          end
          if (s_axis_tlast) begin
            idx_d   = '0;
            state_d = ST_CLEAR;
          end
        end
      end
      // Clear degree counts, visit marks and component flags.
      ST_CLEAR: begin
        fadj_we = 1'b1; fadj_wa = idx_q[NW-1:0];
        radj_we = 1'b1; radj_wa = idx_q[NW-1:0];
        vis_we  = 1'b1;
        hout_we = 1'b1; hout_wa = idx_q[NW-1:0]; hout_wd = 1'b0;
        hin_we  = 1'b1; hin_wa  = idx_q[NW-1:0]; hin_wd  = 1'b0;
        if (idx_q == n_last) begin
          eidx_d  = '0;
          state_d = ST_CNT_RD;
        end else begin
          idx_d = idx_q + CMPW'(1);
        end
      end
      // Count out-degree and in-degree of each node.
      ST_CNT_RD: begin
        if (eidx_q == total_q) begin
          idx_d = '0; sumf_d = '0; sumr_d = '0;
          state_d = ST_PFX_RD;
        end else begin
          e_re    = 1'b1;
          state_d = ST_CNT_CHK;
        end
      end
      ST_CNT_CHK: begin
        a_d = NW'(e_rd[7:0]);
        b_d = NW'(e_rd[15:8]);
        if (e_in_range) begin
          fadj_re = 1'b1; fadj_ra = NW'(e_rd[7:0]);
          radj_re = 1'b1; radj_ra = NW'(e_rd[15:8]);
          state_d = ST_CNT_WR;
        end else begin
          drop_d  = 1'b1;
          eidx_d  = eidx_q + ECW'(1);
          state_d = ST_CNT_RD;
        end
      end
      ST_CNT_WR: begin
        fadj_we = 1'b1; fadj_wd = {ECW'(0), fadj_rd[ECW-1:0] + ECW'(1)};
        radj_we = 1'b1; radj_wd = {ECW'(0), radj_rd[ECW-1:0] + ECW'(1)};
        eidx_d  = eidx_q + ECW'(1);
        state_d = ST_CNT_RD;
      end
      // Running sums give the end of each node's list; the cursor starts there too.
      ST_PFX_RD: begin
        fadj_re = 1'b1; fadj_ra = idx_q[NW-1:0];
        radj_re = 1'b1; radj_ra = idx_q[NW-1:0];
        state_d = ST_PFX_WR;
      end
      ST_PFX_WR: begin
        fadj_we = 1'b1; fadj_wa = idx_q[NW-1:0]; fadj_wd = {sf, sf};
        radj_we = 1'b1; radj_wa = idx_q[NW-1:0]; radj_wd = {sr, sr};
        sumf_d = sf;
        sumr_d = sr;
        if (idx_q == n_last) begin
          eidx_d  = '0;
          state_d = ST_SCT_RD;
        end else begin
          idx_d   = idx_q + CMPW'(1);
          state_d = ST_PFX_RD;
        end
      end
      // Scatter targets, moving each cursor down to the start of its list.
      ST_SCT_RD: begin
        if (eidx_q == total_q) begin
          idx_d = '0; pass2_d = 1'b0; ftot_d = '0; ccnt_d = '0;
          state_d = ST_OUT_A;
        end else begin
          e_re    = 1'b1;
          state_d = ST_SCT_CHK;
        end
      end
      ST_SCT_CHK: begin
        a_d = NW'(e_rd[7:0]);
        b_d = NW'(e_rd[15:8]);
        if (e_in_range) begin
          fadj_re = 1'b1; fadj_ra = NW'(e_rd[7:0]);
          radj_re = 1'b1; radj_ra = NW'(e_rd[15:8]);
          state_d = ST_SCT_WR;
        end else begin
          eidx_d  = eidx_q + ECW'(1);
          state_d = ST_SCT_RD;
        end
      end
      ST_SCT_WR: begin
        ftgt_we = 1'b1;
        rtgt_we = 1'b1;
        fadj_we = 1'b1; fadj_wd = {cf, fadj_rd[ECW-1:0]};
        radj_we = 1'b1; radj_wd = {cr, radj_rd[ECW-1:0]};
        eidx_d  = eidx_q + ECW'(1);
        state_d = ST_SCT_RD;
      end
      // Pick the next start node: in index order, then in reverse finish order.
      ST_OUT_A: begin
        ford_re = pass2_q;
        state_d = ST_OUT_B;
      end
      ST_OUT_B: begin
        cand_d  = pass2_q ? ford_rd : idx_q[NW-1:0];
        vis_re  = 1'b1;
        vis_ra  = pass2_q ? ford_rd : idx_q[NW-1:0];
        state_d = ST_OUT_C;
      end
      ST_OUT_C: begin
        if (!vis_rd) begin
          vis_we = 1'b1; vis_wa = cand_q; vis_wd = 1'b1;
          comp_we = pass2_q;
          stk_we = 1'b1; stk_wa = '0; stk_wd = cand_q;
          depth_d = NCW'(1);
          top_d   = cand_q;
          state_d = ST_VISIT;
        end else begin
          advance = 1'b1;
        end
      end
      // Depth-first walk on the top of the stack.
      ST_VISIT: begin
        fadj_re = !pass2_q; fadj_ra = top_q;
        radj_re = pass2_q;  radj_ra = top_q;
        state_d = ST_ADJ;
      end
      ST_ADJ: begin
        if (adj_cur < adj_end) begin
          ftgt_re = !pass2_q;
          rtgt_re = pass2_q;
          fadj_we = !pass2_q; fadj_wa = top_q; fadj_wd = {adj_cur + ECW'(1), adj_end};
          radj_we = pass2_q;  radj_wa = top_q; radj_wd = {adj_cur + ECW'(1), adj_end};
          state_d = ST_TGT;
        end else begin
          if (!pass2_q) begin
            ford_we = 1'b1;
            ftot_d  = ftot_q + NCW'(1);
          end
          depth_d = depth_q - NCW'(1);
          if (depth_q == NCW'(1)) begin
            if (pass2_q) begin
              ccnt_d = ccnt_q + NCW'(1);
            end
            advance = 1'b1;
          end else begin
            stk_re  = 1'b1;
            state_d = ST_POP;
          end
        end
      end
      ST_TGT: begin
        u_d     = tgt_rd;
        vis_re  = 1'b1;
        vis_ra  = tgt_rd;
        state_d = ST_UCHK;
      end
      ST_UCHK: begin
        if (!vis_rd) begin
          vis_we = 1'b1; vis_wa = u_q; vis_wd = 1'b1;
          comp_we = pass2_q; comp_wa = u_q;
          stk_we  = 1'b1;
          depth_d = depth_q + NCW'(1);
          top_d   = u_q;
        end
        state_d = ST_VISIT;
      end
      ST_POP: begin
        top_d   = stk_rd;
        state_d = ST_VISIT;
      end
      // Clear the visit marks between the two walks.
      ST_VCLR: begin
        vis_we = 1'b1;
        if (idx_q == n_last) begin
          pass2_d = 1'b1;
          state_d = ST_OUT_A;
        end else begin
          idx_d = idx_q + CMPW'(1);
        end
      end
      // Mark components that have an edge leaving or entering them.
      ST_MRK_RD: begin
        if (eidx_q == total_q) begin
          idx_d = '0; nsrc_d = '0; nsnk_d = '0;
          state_d = ST_TAL_RD;
        end else begin
          e_re    = 1'b1;
          state_d = ST_MRK_A;
        end
      end
      ST_MRK_A: begin
        b_d = NW'(e_rd[15:8]);
        if (e_in_range) begin
          comp_re = 1'b1; comp_ra = NW'(e_rd[7:0]);
          state_d = ST_MRK_B;
        end else begin
          eidx_d  = eidx_q + ECW'(1);
          state_d = ST_MRK_RD;
        end
      end
      ST_MRK_B: begin
        ca_d    = comp_rd;
        comp_re = 1'b1; comp_ra = b_q;
        state_d = ST_MRK_C;
      end
      ST_MRK_C: begin
        if (ca_q != comp_rd) begin
          hout_we = 1'b1;
          hin_we  = 1'b1;
        end
        eidx_d  = eidx_q + ECW'(1);
        state_d = ST_MRK_RD;
      end
      // Count sources and sinks among the components.
      ST_TAL_RD: begin
        hout_re = 1'b1;
        hin_re  = 1'b1;
        state_d = ST_TAL_ACC;
      end
      ST_TAL_ACC: begin
        nsrc_d = nsrc_q + NCW'(!hin_rd);
        nsnk_d = nsnk_q + NCW'(!hout_rd);
        if (idx_q == CMPW'(ccnt_q) - CMPW'(1)) begin
          state_d = ST_DONE;
        end else begin
          idx_d   = idx_q + CMPW'(1);
          state_d = ST_TAL_RD;
        end
      end
      // Hand the result to the output register once it is free.
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {6'd0, 9'(ccnt_q), (ccnt_q == NCW'(1)) ? 9'd0 : 9'(max_ss)};
          m_user_d  = drop_q;
          total_d   = '0;
          drop_d    = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Move to the next start node, or on to the next phase.
    if (advance) begin
      if (!pass2_q) begin
        if (idx_q == n_last) begin
          idx_d   = '0;
          state_d = ST_VCLR;
        end else begin
          idx_d   = idx_q + CMPW'(1);
          state_d = ST_OUT_A;
        end
      end else begin
        if (idx_q == '0) begin
          eidx_d  = '0;
          state_d = ST_MRK_RD;
        end else begin
          idx_d   = idx_q - CMPW'(1);
          state_d = ST_OUT_A;
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      total_q      <= '0;
      drop_q       <= 1'b0;
      node_count_q <= 9'd1;
      m_valid_q    <= 1'b0;
      depth_q      <= '0;
      ccnt_q       <= '0;
      pass2_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      total_q   <= total_d;
      drop_q    <= drop_d;
      m_valid_q <= m_valid_d;
      depth_q   <= depth_d;
      ccnt_q    <= ccnt_d;
      pass2_q   <= pass2_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;  eidx_q <= eidx_d; sumf_q <= sumf_d; sumr_q <= sumr_d;
    a_q    <= a_d;    b_q    <= b_d;    cand_q <= cand_d; top_q  <= top_d;
    u_q    <= u_d;    ca_q   <= ca_d;   ftot_q <= ftot_d;
    nsrc_q <= nsrc_d; nsnk_q <= nsnk_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  // Memories.
  scc_ram #(.WIDTH(16), .DEPTH(MAX_EDGES)) u_edge (
    .clk_i, .we_i(e_we), .waddr_i(e_wa), .wdata_i(e_wd),
    .re_i(e_re), .raddr_i(e_ra), .rdata_o(e_rd));
  scc_ram #(.WIDTH(AJW), .DEPTH(MAX_NODES)) u_fadj (
    .clk_i, .we_i(fadj_we), .waddr_i(fadj_wa), .wdata_i(fadj_wd),
    .re_i(fadj_re), .raddr_i(fadj_ra), .rdata_o(fadj_rd));
  scc_ram #(.WIDTH(AJW), .DEPTH(MAX_NODES)) u_radj (
    .clk_i, .we_i(radj_we), .waddr_i(radj_wa), .wdata_i(radj_wd),
    .re_i(radj_re), .raddr_i(radj_ra), .rdata_o(radj_rd));
  scc_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_ftgt (
    .clk_i, .we_i(ftgt_we), .waddr_i(ftgt_wa), .wdata_i(ftgt_wd),
    .re_i(ftgt_re), .raddr_i(ftgt_ra), .rdata_o(ftgt_rd));
  scc_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_rtgt (
    .clk_i, .we_i(rtgt_we), .waddr_i(rtgt_wa), .wdata_i(rtgt_wd),
    .re_i(rtgt_re), .raddr_i(rtgt_ra), .rdata_o(rtgt_rd));
  scc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_vis (
    .clk_i, .we_i(vis_we), .waddr_i(vis_wa), .wdata_i(vis_wd),
    .re_i(vis_re), .raddr_i(vis_ra), .rdata_o(vis_rd));
  scc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_ford (
    .clk_i, .we_i(ford_we), .waddr_i(ford_wa), .wdata_i(ford_wd),
    .re_i(ford_re), .raddr_i(ford_ra), .rdata_o(ford_rd));
  scc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_comp (
    .clk_i, .we_i(comp_we), .waddr_i(comp_wa), .wdata_i(comp_wd),
    .re_i(comp_re), .raddr_i(comp_ra), .rdata_o(comp_rd));
  scc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_stk (
    .clk_i, .we_i(stk_we), .waddr_i(stk_wa), .wdata_i(stk_wd),
    .re_i(stk_re), .raddr_i(stk_ra), .rdata_o(stk_rd));
  scc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_hout (
    .clk_i, .we_i(hout_we), .waddr_i(hout_wa), .wdata_i(hout_wd),
    .re_i(hout_re), .raddr_i(hout_ra), .rdata_o(hout_rd));
  scc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_hin (
    .clk_i, .we_i(hin_we), .waddr_i(hin_wa), .wdata_i(hin_wd),
    .re_i(hin_re), .raddr_i(hin_ra), .rdata_o(hin_rd));

  // Checks on the walk and on the result.
  `SCC_ASSERT_ALWAYS(a_depth_bound, depth_q <= NCW'(MAX_NODES), "walk stack overflow")
  `SCC_ASSERT_IMPL(a_comp_bound, state_q == ST_DONE, CMPW'(ccnt_q) <= n_use, "too many components")
  `SCC_ASSERT_IMPL(a_pfx_total, state_q == ST_SCT_RD, sumf_q <= total_q && sumr_q <= total_q,
    "degree sums exceed stored edges")
  `SCC_ASSERT_IMPL(a_result_comps, m_valid_q, m_data_q[17:9] != 9'd0,
    "result without components")

endmodule

FILE: rtl/scc_ram.sv
module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: tb/scc_strong_augment_count_checker.sv
module scc_strong_augment_count_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxNodes = 256;
  localparam int MaxEdges = 1024;

  typedef struct packed {
    logic [8:0] extra_edges;
    logic [8:0] component_count;
    logic       edge_dropped;
  } augment_res_t;

  // Shadow copy of the block's graph store and register.
  logic [7:0] start_store[MaxEdges];
  logic [7:0] end_store[MaxEdges];
  int         stored_edges;
  logic       drop_seen;
  logic [8:0] node_reg;

  // Working tables for the component search.
  int         fwd_off[MaxNodes+1];
  int         rev_off[MaxNodes+1];
  int         fwd_tgt[MaxEdges];
  int         rev_tgt[MaxEdges];
  int         cursor[MaxNodes];
  int         finish_seq[MaxNodes];
  int         comp_id[MaxNodes];
  int         dfs_stack[MaxNodes];
  logic [1:0] mark[MaxNodes];
  int         finish_total;

  augment_res_t expected_q[$];

  function automatic int active_nodes();
    if (node_reg == 0) return 1;
    if (node_reg > MaxNodes) return MaxNodes;
    return int'(node_reg);
  endfunction

  // Iterative depth-first walk; the forward pass records finish order, the
  // reverse pass labels every reached node with the component number.
  function automatic void walk_graph(int root, bit rev, int comp);
    int depth;
    int v;
    int u;
    depth = 0;
    mark[root] = 1;
    if (rev) comp_id[root] = comp;
    cursor[root] = rev ? rev_off[root] : fwd_off[root];
    dfs_stack[depth++] = root;
    while (depth > 0) begin
      v = dfs_stack[depth-1];
      if (cursor[v] < (rev ? rev_off[v+1] : fwd_off[v+1])) begin
        u = rev ? rev_tgt[cursor[v]] : fwd_tgt[cursor[v]];
        cursor[v]++;
        if (mark[u] == 0 && depth < MaxNodes) begin
          mark[u] = 1;
          if (rev) comp_id[u] = comp;
          cursor[u] = rev ? rev_off[u] : fwd_off[u];
          dfs_stack[depth++] = u;
        end
      end else begin
        mark[v] = 2;
        depth--;
        if (!rev && finish_total < MaxNodes) finish_seq[finish_total++] = v;
      end
    end
  endfunction

  // Kosaraju search followed by source and sink counting.
  function automatic augment_res_t predict_augment();
    augment_res_t res;
    int n, a, b, cnt, srcs, snks, ca, cb;
    bit has_in[MaxNodes];
    bit has_out[MaxNodes];
    n = active_nodes();
    for (int i = 0; i <= MaxNodes; i++) begin
      fwd_off[i] = 0;
      rev_off[i] = 0;
    end
    for (int i = 0; i < stored_edges; i++) begin
      a = start_store[i];
      b = end_store[i];
      if (a >= n || b >= n) begin
        drop_seen = 1'b1;
        continue;
      end
      fwd_off[a+1]++;
      rev_off[b+1]++;
    end
    for (int i = 0; i < n; i++) begin
      fwd_off[i+1] += fwd_off[i];
      rev_off[i+1] += rev_off[i];
    end
    for (int i = 0; i < n; i++) cursor[i] = fwd_off[i];
    for (int i = 0; i < stored_edges; i++) begin
      a = start_store[i];
      b = end_store[i];
      if (a < n && b < n) fwd_tgt[cursor[a]++] = b;
    end
    for (int i = 0; i < n; i++) cursor[i] = rev_off[i];
    for (int i = 0; i < stored_edges; i++) begin
      a = start_store[i];
      b = end_store[i];
      if (a < n && b < n) rev_tgt[cursor[b]++] = a;
    end

    for (int i = 0; i < MaxNodes; i++) mark[i] = 0;
    finish_total = 0;
    for (int i = 0; i < n; i++) if (mark[i] == 0) walk_graph(i, 1'b0, 0);

    for (int i = 0; i < MaxNodes; i++) mark[i] = 0;
    cnt = 0;
    for (int i = finish_total; i > 0; i--) begin
      if (mark[finish_seq[i-1]] == 0) begin
        walk_graph(finish_seq[i-1], 1'b1, cnt);
        cnt++;
      end
    end

    for (int i = 0; i < MaxNodes; i++) begin
      has_in[i] = 1'b0;
      has_out[i] = 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      for (int e = fwd_off[i]; e < fwd_off[i+1]; e++) begin
        ca = comp_id[i];
        cb = comp_id[fwd_tgt[e]];
        if (ca != cb) begin
          has_out[ca] = 1'b1;
          has_in[cb] = 1'b1;
        end
      end
    end
    srcs = 0;
    snks = 0;
    for (int i = 0; i < cnt; i++) begin
      if (!has_in[i]) srcs++;
      if (!has_out[i]) snks++;
    end
    res.component_count = cnt[8:0];
    res.extra_edges = (cnt == 1) ? 9'd0 : ((srcs > snks) ? srcs[8:0] : snks[8:0]);
    res.edge_dropped = drop_seen;
    return res;
  endfunction

  // Results are compared first, so an expectation queued in the same cycle
  // can never be taken by an older result.
  always @(posedge clk_i or negedge rst_ni) begin
    augment_res_t got;
    augment_res_t want;
    int n;
    if (!rst_ni) begin
      stored_edges = 0;
      drop_seen = 1'b0;
      node_reg = 9'd1;
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.extra_edges = m_axis_tdata[8:0];
        got.component_count = m_axis_tdata[17:9];
        got.edge_dropped = m_axis_tuser;
        if (expected_q.size() == 0) begin
          $display("%0t: result with none expected: actual %p", $time, got);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (got.extra_edges !== want.extra_edges) begin
            $display("%0t: extra_edges expected %0d actual %0d", $time,
                     want.extra_edges, got.extra_edges);
            fail_count_o++;
          end
          if (got.component_count !== want.component_count) begin
            $display("%0t: component_count expected %0d actual %0d", $time,
                     want.component_count, got.component_count);
            fail_count_o++;
          end
          if (got.edge_dropped !== want.edge_dropped) begin
            $display("%0t: edge_dropped expected %0b actual %0b", $time,
                     want.edge_dropped, got.edge_dropped);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser) begin
          n = active_nodes();
          if (s_axis_tdata[7:0] >= n || s_axis_tdata[15:8] >= n || stored_edges >= MaxEdges) begin
            drop_seen = 1'b1;
          end else begin
            start_store[stored_edges] = s_axis_tdata[7:0];
            end_store[stored_edges] = s_axis_tdata[15:8];
            stored_edges++;
          end
        end
        if (s_axis_tlast) begin
          expected_q = {expected_q, predict_augment()};
          stored_edges = 0;
          drop_seen = 1'b0;
        end
      end
      if (cfg_we_i) node_reg = cfg_wdata_i;
    end
    pending_o = expected_q.size();
  end

endmodule

FILE: tb/scc_strong_augment_count_tb.sv
module scc_strong_augment_count_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 2000000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [8:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  int          fail_count;
  int          pending;
  int          items_sent;
  int          cycle_cnt;
  int          sink_stall;
  bit          quiet;
  int          nodes_now;

  scc_strong_augment_count i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  scc_strong_augment_count_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: after each taken result it holds off for a random number of cycles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        sink_stall = quiet ? 0 : $urandom_range(0, 10);
      end else if (sink_stall > 0) begin
        sink_stall--;
      end
      m_axis_tready <= (sink_stall == 0);
    end
  end

  // One request on the edge input, with a random gap ahead of it.
  task automatic send_edge(input logic [7:0] src, input logic [7:0] dst,
                           input logic valid, input logic last);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {dst, src};
    s_axis_tuser <= valid;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (last) s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (pending != 0);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_nodes(input logic [8:0] value);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    nodes_now = (value == 0) ? 1 : ((value > 256) ? 256 : int'(value));
  endtask

  // A random graph: mostly in-range edges, with some empty markers and
  // out-of-range nodes mixed in.
  task automatic random_graph(input int edges);
    int sel;
    logic [7:0] src;
    logic [7:0] dst;
    quiet = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < edges; k++) begin
      sel = $urandom_range(0, 99);
      src = 8'($urandom_range(0, nodes_now - 1));
      dst = 8'($urandom_range(0, nodes_now - 1));
      if (sel < 6) src = 8'($urandom_range(0, 255));
      else if (sel < 12) dst = 8'($urandom_range(0, 255));
      send_edge(src, dst, (sel < 95), (k == edges - 1));
    end
  endtask

  initial begin
    int phase_nodes[12] = '{2, 3, 7, 16, 1, 0, 33, 256, 511, 12, 64, 5};
    int p;
    int graphs;
    int span;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    items_sent = 0;
    cycle_cnt = 0;
    quiet = 1'b0;
    nodes_now = 1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset node count: a self loop, then an empty graph.
    send_edge(8'd0, 8'd0, 1'b1, 1'b1);
    send_edge(8'd0, 8'd0, 1'b0, 1'b1);

    // Five nodes: one cycle, a chain, and dropped edges.
    set_nodes(9'd5);
    for (int k = 0; k < 5; k++) send_edge(8'(k), 8'((k + 1) % 5), 1'b1, k == 4);
    send_edge(8'd0, 8'd1, 1'b1, 1'b0);
    send_edge(8'd1, 8'd2, 1'b1, 1'b0);
    send_edge(8'd3, 8'd3, 1'b0, 1'b0);
    send_edge(8'd1, 8'd2, 1'b1, 1'b1);
    send_edge(8'd7, 8'd0, 1'b1, 1'b0);
    send_edge(8'd0, 8'd255, 1'b1, 1'b0);
    send_edge(8'd255, 8'd255, 1'b1, 1'b1);

    // Zero count behaves as one node; an oversized count saturates.
    set_nodes(9'd0);
    send_edge(8'd0, 8'd0, 1'b1, 1'b0);
    send_edge(8'd1, 8'd0, 1'b1, 1'b1);
    set_nodes(9'd511);
    send_edge(8'd255, 8'd0, 1'b1, 1'b0);
    send_edge(8'd0, 8'd255, 1'b1, 1'b0);
    send_edge(8'd170, 8'd85, 1'b1, 1'b1);

    // Overfill the edge store on a small graph.
    set_nodes(9'd4);
    quiet = 1'b1;
    for (int k = 0; k < 1030; k++) begin
      send_edge(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)), 1'b1, k == 1029);
    end

    // Random graphs across a spread of node counts.
    p = 0;
    while (items_sent < 1450) begin
      set_nodes(9'(phase_nodes[p % 12]));
      graphs = (nodes_now > 64) ? 2 : 8;
      span = (3 * nodes_now < 40) ? 3 * nodes_now : 40;
      for (int g = 0; g < graphs && items_sent < 1450; g++) begin
        random_graph($urandom_range(1, span));
      end
      p++;
    end
    quiet = 1'b0;

    wait_idle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
